>>> rtl/fwufr_pkg.sv
package fwufr_pkg;

    // Frame command bytes
    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_DATA  = 8'h02;
    localparam logic [7:0] CMD_END   = 8'h03;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1021;

    // Header byte counts
    localparam logic [2:0] SIZE_BYTES = 3'd4;
    localparam logic [2:0] LEN_BYTES  = 3'd2;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_SIZE,
        PH_LEN,
        PH_PAYLOAD
    } phase_t;

    typedef struct packed {
        logic [31:0] frames_count;
        logic [31:0] bytes_count;
        logic        receiving;
        logic        size_mismatch;
        logic        update_done;
        logic        resp_nak;
        logic        resp_valid;
        logic [7:0]  write_byte;
        logic        write_valid;
    } result_t;

endpackage

>>> rtl/firmware_update_frame_receiver_unit.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+------------------------------------------
// s_        | in        | s_tvalid / s_tready    | tdata: rx_byte[7:0]; tuser: op
// m_        | out       | m_tvalid / m_tready    | tdata: write_byte, update_done, size_mismatch,
//           |           |                        |   receiving, bytes_count, frames_count
//           |           |                        | tuser: write_valid, resp_valid, resp_nak
// cfg_      | in        | cfg_valid / cfg_ready  | cfg_data: max_payload[15:0]
//
// Each input beat gives exactly one result beat, registered in the cycle after it is taken.
// The whole parser update is one pass of logic into the result register, so a
// beat is taken every cycle as long as the result register is free or drains
// in the same cycle (one beat per cycle sustained).
// aresetn is synchronous, active low; it clears the parser, the session and
// max_payload (back to 1021). cfg_ready is always high.
// A stall on m_tready holds the result and stops s_tready until it is taken.
module firmware_update_frame_receiver_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tuser,    // [0] op: 1 = link reset

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [7:0] write_byte, [8] update_done, [9] size_mismatch,
                                    // [10] receiving, [42:11] bytes_count,
                                    // [74:43] frames_count, [79:75] zero
    output logic [2:0]  m_tuser,    // [0] write_valid, [1] resp_valid, [2] resp_nak

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data    // [15:0] max_payload
);

    // Parser and session state
    fwufr_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  hdr_pos_reg, hdr_pos_next;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [15:0] left_reg, left_next;
    logic [31:0] size_sh_reg, size_sh_next;
    logic        discard_reg, discard_next;
    logic        active_reg, active_next;
    logic [31:0] ann_size_reg, ann_size_next;
    logic [31:0] byte_tot_reg, byte_tot_next;
    logic [31:0] frame_tot_reg, frame_tot_next;
    logic [15:0] max_pay_reg;

    // Result register
    fwufr_pkg::result_t out_reg, out_next;
    logic               out_valid_reg;

    logic        s_fire;
    logic [7:0]  b;
    logic [2:0]  pos_inc;
    logic [15:0] len_shift;
    logic [15:0] left_dec;

    assign s_tready  = !out_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign b         = s_tdata;
    assign pos_inc   = hdr_pos_reg + 3'd1;
    assign len_shift = {frame_len_reg[7:0], b};
    assign left_dec  = left_reg - 16'd1;

    always_comb begin
        phase_next     = phase_reg;
        hdr_pos_next   = hdr_pos_reg;
        frame_len_next = frame_len_reg;
        left_next      = left_reg;
        size_sh_next   = size_sh_reg;
        discard_next   = discard_reg;
        active_next    = active_reg;
        ann_size_next  = ann_size_reg;
        byte_tot_next  = byte_tot_reg;
        frame_tot_next = frame_tot_reg;
        out_next       = '0;

        if (s_tuser) begin
            // link reset: everything back to idle, result all zero
            phase_next     = fwufr_pkg::PH_CMD;
            hdr_pos_next   = '0;
            frame_len_next = '0;
            left_next      = '0;
            size_sh_next   = '0;
            discard_next   = 1'b0;
            active_next    = 1'b0;
            ann_size_next  = '0;
            byte_tot_next  = '0;
            frame_tot_next = '0;
        end else begin
            case (phase_reg)
                fwufr_pkg::PH_CMD: begin
                    if (b == fwufr_pkg::CMD_START) begin
                        phase_next   = fwufr_pkg::PH_SIZE;
                        hdr_pos_next = '0;
                        size_sh_next = '0;
                    end else if (b == fwufr_pkg::CMD_DATA) begin
                        phase_next     = fwufr_pkg::PH_LEN;
                        hdr_pos_next   = '0;
                        frame_len_next = '0;
                    end else if (b == fwufr_pkg::CMD_END) begin
                        out_next.resp_valid = 1'b1;
                        if (active_reg) begin
                            out_next.update_done   = 1'b1;
                            out_next.size_mismatch = (byte_tot_reg != ann_size_reg);
                            active_next            = 1'b0;
                        end else begin
                            out_next.resp_nak = 1'b1;
                        end
                    end
                end
                fwufr_pkg::PH_SIZE: begin
                    size_sh_next = {size_sh_reg[23:0], b};
                    hdr_pos_next = pos_inc;
                    if (pos_inc >= fwufr_pkg::SIZE_BYTES) begin
                        out_next.resp_valid = 1'b1;
                        if (active_reg) begin
                            out_next.resp_nak = 1'b1;
                        end else begin
                            active_next    = 1'b1;
                            ann_size_next  = {size_sh_reg[23:0], b};
                            byte_tot_next  = '0;
                            frame_tot_next = '0;
                        end
                        phase_next   = fwufr_pkg::PH_CMD;
                        hdr_pos_next = '0;
                    end
                end
                fwufr_pkg::PH_LEN: begin
                    frame_len_next = len_shift;
                    hdr_pos_next   = pos_inc;
                    if (pos_inc >= fwufr_pkg::LEN_BYTES) begin
                        hdr_pos_next = '0;
                        if (len_shift > max_pay_reg) begin
                            out_next.resp_valid = 1'b1;
                            out_next.resp_nak   = 1'b1;
                            phase_next          = fwufr_pkg::PH_CMD;
                        end else begin
                            left_next = len_shift;
                            if (len_shift == '0) begin
                                // empty frame: answer right after the length
                                out_next.resp_valid = 1'b1;
                                out_next.resp_nak   = !active_reg;
                                if (active_reg) begin
                                    frame_tot_next = frame_tot_reg + 32'd1;
                                end
                                discard_next = 1'b0;
                                phase_next   = fwufr_pkg::PH_CMD;
                            end else begin
                                discard_next = !active_reg;
                                phase_next   = fwufr_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                end
                fwufr_pkg::PH_PAYLOAD: begin
                    if (!discard_reg) begin
                        out_next.write_valid = 1'b1;
                        out_next.write_byte  = b;
                        byte_tot_next        = byte_tot_reg + 32'd1;
                    end
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        out_next.resp_valid = 1'b1;
                        out_next.resp_nak   = discard_reg;
                        if (!discard_reg) begin
                            frame_tot_next = frame_tot_reg + 32'd1;
                        end
                        discard_next = 1'b0;
                        phase_next   = fwufr_pkg::PH_CMD;
                    end
                end
                default: begin
                    phase_next = fwufr_pkg::PH_CMD;
                end
            endcase
        end

        out_next.receiving    = active_next;
        out_next.bytes_count  = byte_tot_next;
        out_next.frames_count = frame_tot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= fwufr_pkg::PH_CMD;
            hdr_pos_reg   <= '0;
            frame_len_reg <= '0;
            left_reg      <= '0;
            size_sh_reg   <= '0;
            discard_reg   <= 1'b0;
            active_reg    <= 1'b0;
            ann_size_reg  <= '0;
            byte_tot_reg  <= '0;
            frame_tot_reg <= '0;
            max_pay_reg   <= fwufr_pkg::MAX_PAYLOAD_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_pay_reg <= cfg_data;
            end
            if (s_fire) begin
                phase_reg     <= phase_next;
                hdr_pos_reg   <= hdr_pos_next;
                frame_len_reg <= frame_len_next;
                left_reg      <= left_next;
                size_sh_reg   <= size_sh_next;
                discard_reg   <= discard_next;
                active_reg    <= active_next;
                ann_size_reg  <= ann_size_next;
                byte_tot_reg  <= byte_tot_next;
                frame_tot_reg <= frame_tot_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.frames_count, out_reg.bytes_count, out_reg.receiving,
                       out_reg.size_mismatch, out_reg.update_done, out_reg.write_byte};
    assign m_tuser  = {out_reg.resp_nak, out_reg.resp_valid, out_reg.write_valid};

    // Assertions
    a_done_is_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.update_done |->
            out_reg.resp_valid && !out_reg.resp_nak && !out_reg.receiving)
        else $error("done pulse without ACK or with session still open");

    a_write_in_session: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.write_valid |-> out_reg.receiving && !out_reg.update_done)
        else $error("payload byte forwarded outside a session");

    a_mismatch_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.size_mismatch |-> out_reg.update_done)
        else $error("size mismatch flag without done pulse");

    a_beat_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> out_valid_reg)
        else $error("accepted beat produced no result");

endmodule

>>> dv/tb_firmware_update_frame_receiver_unit.sv
`timescale 1ns / 1ps

module tb_firmware_update_frame_receiver_unit;

    // Stall limit: cycles with no beat on any channel before giving up.
    // The longest legal quiet stretch is the receiver hold-off.
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 200;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // [7:0] rx_byte
    logic        s_tuser = 1'b0;     // [0] op: 1 = link reset

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;            // [7:0] write_byte, [8] update_done, [9] size_mismatch,
                                     // [10] receiving, [42:11] bytes_count,
                                     // [74:43] frames_count, [79:75] zero
    logic [2:0]  m_tuser;            // [0] write_valid, [1] resp_valid, [2] resp_nak

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000; // [15:0] max_payload

    firmware_update_frame_receiver_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser mirror: own copy of the session and framing state
    // ------------------------------------------------------------------
    fwufr_pkg::phase_t frame_phase;
    logic [2:0]  hdr_pos;
    logic [15:0] frame_len;
    logic [15:0] payload_left;
    logic [31:0] size_accum;
    logic        drop_frame;
    logic        in_session;
    logic [31:0] announced_size;
    logic [31:0] byte_count;
    logic [31:0] frame_count;
    logic [15:0] max_payload;

    fwufr_pkg::result_t parser_results_due[$];   // one per accepted input beat, oldest first

    int          beats_sent = 0;
    int          bad_results = 0;
    int          src_idle_pct = 0;        // sender gap chance, percent
    int          snk_idle_pct = 0;        // receiver stall chance, percent
    int          hold_request = 0;        // long receiver hold-off, picked up by the checker

    function automatic void clear_link_state();
        frame_phase    = fwufr_pkg::PH_CMD;
        hdr_pos        = '0;
        frame_len      = '0;
        payload_left   = '0;
        size_accum     = '0;
        drop_frame     = 1'b0;
        in_session     = 1'b0;
        announced_size = '0;
        byte_count     = '0;
        frame_count    = '0;
    endfunction

    // End of a DATA frame: ACK counts the frame, NAK if it was being dropped.
    function automatic void close_data_frame(inout fwufr_pkg::result_t r);
        r.resp_valid = 1'b1;
        if (drop_frame) begin
            r.resp_nak = 1'b1;
        end else begin
            frame_count = frame_count + 32'd1;
        end
        drop_frame  = 1'b0;
        frame_phase = fwufr_pkg::PH_CMD;
    endfunction

    function automatic fwufr_pkg::result_t parse_link_byte(logic op, logic [7:0] b);
        fwufr_pkg::result_t r;
        r = '0;
        if (op) begin
            clear_link_state();
        end else begin
            case (frame_phase)
                fwufr_pkg::PH_CMD: begin
                    if (b == fwufr_pkg::CMD_START) begin
                        frame_phase = fwufr_pkg::PH_SIZE;
                        hdr_pos     = '0;
                        size_accum  = '0;
                    end else if (b == fwufr_pkg::CMD_DATA) begin
                        frame_phase = fwufr_pkg::PH_LEN;
                        hdr_pos     = '0;
                        frame_len   = '0;
                    end else if (b == fwufr_pkg::CMD_END) begin
                        r.resp_valid = 1'b1;
                        if (in_session) begin
                            r.update_done   = 1'b1;
                            r.size_mismatch = (byte_count != announced_size);
                            in_session      = 1'b0;
                        end else begin
                            r.resp_nak = 1'b1;
                        end
                    end
                    // anything else is silently dropped
                end
                fwufr_pkg::PH_SIZE: begin
                    size_accum = {size_accum[23:0], b};
                    hdr_pos    = hdr_pos + 3'd1;
                    if (hdr_pos >= fwufr_pkg::SIZE_BYTES) begin
                        r.resp_valid = 1'b1;
                        if (in_session) begin
                            r.resp_nak = 1'b1;      // START while busy
                        end else begin
                            in_session     = 1'b1;
                            announced_size = size_accum;
                            byte_count     = '0;
                            frame_count    = '0;
                        end
                        frame_phase = fwufr_pkg::PH_CMD;
                        hdr_pos     = '0;
                    end
                end
                fwufr_pkg::PH_LEN: begin
                    frame_len = {frame_len[7:0], b};
                    hdr_pos   = hdr_pos + 3'd1;
                    if (hdr_pos >= fwufr_pkg::LEN_BYTES) begin
                        hdr_pos = '0;
                        if (frame_len > max_payload) begin
                            // oversized: NAK now, next byte is a command
                            r.resp_valid = 1'b1;
                            r.resp_nak   = 1'b1;
                            frame_phase  = fwufr_pkg::PH_CMD;
                        end else begin
                            drop_frame   = !in_session;
                            payload_left = frame_len;
                            if (payload_left == 16'd0) begin
                                close_data_frame(r);
                            end else begin
                                frame_phase = fwufr_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                end
                fwufr_pkg::PH_PAYLOAD: begin
                    if (!drop_frame) begin
                        r.write_valid = 1'b1;
                        r.write_byte  = b;
                        byte_count    = byte_count + 32'd1;
                    end
                    payload_left = payload_left - 16'd1;
                    if (payload_left == 16'd0) begin
                        close_data_frame(r);
                    end
                end
                default: frame_phase = fwufr_pkg::PH_CMD;
            endcase
        end
        r.receiving    = in_session;
        r.bytes_count  = byte_count;
        r.frames_count = frame_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker and receiver-side stalls
    // ------------------------------------------------------------------
    fwufr_pkg::result_t got_result;
    fwufr_pkg::result_t want_result;
    int      hold_left = 0;

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            bad_results++;
        end
    endtask

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            got_result.write_byte    = m_tdata[7:0];
            got_result.update_done   = m_tdata[8];
            got_result.size_mismatch = m_tdata[9];
            got_result.receiving     = m_tdata[10];
            got_result.bytes_count   = m_tdata[42:11];
            got_result.frames_count  = m_tdata[74:43];
            got_result.write_valid   = m_tuser[0];
            got_result.resp_valid    = m_tuser[1];
            got_result.resp_nak      = m_tuser[2];
            if (parser_results_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %h %h",
                         $time, m_tuser, m_tdata);
                bad_results++;
            end else begin
                want_result = parser_results_due.pop_front();
                check_field("write_valid", 32'(want_result.write_valid),
                            32'(got_result.write_valid));
                check_field("write_byte", 32'(want_result.write_byte),
                            32'(got_result.write_byte));
                check_field("resp_valid", 32'(want_result.resp_valid),
                            32'(got_result.resp_valid));
                check_field("resp_nak", 32'(want_result.resp_nak), 32'(got_result.resp_nak));
                check_field("update_done", 32'(want_result.update_done),
                            32'(got_result.update_done));
                check_field("size_mismatch", 32'(want_result.size_mismatch),
                            32'(got_result.size_mismatch));
                check_field("receiving", 32'(want_result.receiving),
                            32'(got_result.receiving));
                check_field("bytes_count", want_result.bytes_count, got_result.bytes_count);
                check_field("frames_count", want_result.frames_count, got_result.frames_count);
            end
        end
        // long hold-off first, random stalls otherwise
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any beat on any channel restarts the count
    // ------------------------------------------------------------------
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Link byte driver
    // ------------------------------------------------------------------
    // tvalid stays high from one beat to the next unless a gap is drawn.
    task automatic send_beat(logic op, logic [7:0] b);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        parser_results_due.push_back(parse_link_byte(op, b));
        beats_sent++;
    endtask

    task automatic send_link_reset();
        send_beat(1'b1, 8'($urandom_range(255)));
    endtask

    task automatic send_start(logic [31:0] size);
        send_beat(1'b0, fwufr_pkg::CMD_START);
        send_beat(1'b0, size[31:24]);
        send_beat(1'b0, size[23:16]);
        send_beat(1'b0, size[15:8]);
        send_beat(1'b0, size[7:0]);
    endtask

    task automatic send_data_header(logic [15:0] len);
        send_beat(1'b0, fwufr_pkg::CMD_DATA);
        send_beat(1'b0, len[15:8]);
        send_beat(1'b0, len[7:0]);
    endtask

    task automatic send_payload(int n);
        repeat (n) send_beat(1'b0, 8'($urandom_range(255)));
    endtask

    // Stop offering, wait for every result, then let the pipe settle.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (parser_results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_max_payload(logic [15:0] v);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        max_payload = v;
    endtask

    // One update session: START, a few DATA frames, usually END.
    // Size mostly matches the accepted payload total.
    task automatic send_update_session();
        int          n_frames;
        int          lens[4];
        logic [31:0] total;
        int          lim;
        n_frames = $urandom_range(0, 4);
        total    = '0;
        lim      = (max_payload < 16'd12) ? int'(max_payload) + 1 : 12;
        for (int i = 0; i < n_frames; i++) begin
            lens[i] = ($urandom_range(99) < 5) ? $urandom_range(0, 64) : $urandom_range(0, lim);
            if (lens[i] <= max_payload) total += lens[i];
        end
        send_start(($urandom_range(99) < 70) ? total : $urandom());
        for (int i = 0; i < n_frames; i++) begin
            send_data_header(16'(lens[i]));
            if (lens[i] <= max_payload) send_payload(lens[i]);  // oversized: no payload
        end
        if ($urandom_range(99) < 85) send_beat(1'b0, fwufr_pkg::CMD_END);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // END and DATA with no session: both NAK, DATA payload not forwarded;
    // unknown commands dropped; link reset.
    task automatic test_idle_commands();
        send_beat(1'b0, fwufr_pkg::CMD_END);
        send_data_header(16'd1);
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'hFF);
        send_beat(1'b1, 8'hFF);
    endtask

    // START, START while busy, empty DATA, DATA, END with matching size.
    task automatic test_session_flow();
        send_start(32'h0000_0002);
        send_start(32'hFFFF_FFFF);
        send_data_header(16'd0);
        send_data_header(16'd2);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, fwufr_pkg::CMD_END);
    endtask

    // Length above the limit: NAK after the length, then END parsed as command.
    task automatic test_oversized_frame();
        send_data_header(16'hFFFF);
        send_beat(1'b0, fwufr_pkg::CMD_END);
    endtask

    // Mostly well-formed sessions, plus stray commands, noise and broken sessions.
    task automatic test_random_sessions(int n_beats);
        int target;
        int pick;
        target = beats_sent + n_beats;
        while (beats_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_update_session();
            end else if (pick < 80) begin
                case ($urandom_range(2))
                    0: send_beat(1'b0, fwufr_pkg::CMD_END);
                    1: begin
                        send_data_header(16'($urandom_range(0, 3)));
                        if (frame_phase == fwufr_pkg::PH_PAYLOAD)
                            send_payload(int'(payload_left));
                    end
                    default: send_beat(1'b0, 8'($urandom_range(255)));
                endcase
            end else if (pick < 90) begin
                send_payload($urandom_range(1, 6));
                send_link_reset();
            end else if (pick < 95) begin
                send_link_reset();
            end else begin
                // session cut short by a link reset
                send_start($urandom());
                send_data_header(16'($urandom_range(2, 8)));
                send_payload($urandom_range(0, 1));
                send_link_reset();
            end
        end
    endtask

    // Receiver holds off for a long stretch while bytes keep coming,
    // so the result register fills and s_tready drops.
    task automatic test_backpressure_fill();
        int target;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_request = HOLD_OFF_CYCLES;
        target = beats_sent + 40;
        while (beats_sent < target) send_update_session();
    endtask

    initial begin
        clear_link_state();
        max_payload = fwufr_pkg::MAX_PAYLOAD_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 31;
        snk_idle_pct = 81;
        test_idle_commands();
        test_session_flow();
        test_oversized_frame();
        set_max_payload(16'h0000);          // only empty frames pass
        test_random_sessions(60);

        src_idle_pct = 81;
        snk_idle_pct = 31;
        set_max_payload(16'hFFFF);
        test_random_sessions(150);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_max_payload(16'($urandom_range(1, 16)));
        test_random_sessions(120);
        set_max_payload(16'($urandom_range(0, 16)));
        test_random_sessions(100);

        test_backpressure_fill();

        set_max_payload(fwufr_pkg::MAX_PAYLOAD_RESET);
        test_random_sessions(100);

        wait_for_drain();
        if (bad_results == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
